@@ hdl/i2a_pkg.sv @@
// Package for the integer to ASCII formatter: opcodes, prefix kinds,
// the stack control bundle and the character lookup functions.
// No dependencies.
package i2a_pkg;

    // Conversion selectors carried on tuser
    localparam logic [1:0] OP_DEC = 2'd0;
    localparam logic [1:0] OP_PTR = 2'd1;
    localparam logic [1:0] OP_HEX_LO = 2'd2;
    localparam logic [1:0] OP_HEX_UP = 2'd3;

    localparam int DIGIT_DEPTH_DEF = 20;
    localparam int VALUE_W = 64;
    localparam int OP_W = 2;
    localparam int CHAR_W = 7;
    localparam int TOTAL_W = 31;
    localparam int OUT_DATA_W = 40;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Reciprocal of ten for a 32-bit dividend, quotient is product >> 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    // Text emitted ahead of the digits
    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_MINUS = 2'd1,
        PFX_HEX = 2'd2,
        PFX_NIL = 2'd3
    } t_prefix;

    // Digit stack control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    // Number of prefix characters for a kind
    function automatic logic [2:0] prefix_len(t_prefix kind);
        logic [2:0] len;
        unique case (kind)
            PFX_MINUS: len = 3'd1;
            PFX_HEX:   len = 3'd2;
            PFX_NIL:   len = 3'd5;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // Prefix character at a position: "-", "0x" or "(nil)"
    function automatic logic [CHAR_W-1:0] prefix_char(t_prefix kind, logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        c = 7'h30;
        unique case (kind)
            PFX_MINUS: c = 7'h2D;
            PFX_HEX:   c = (idx == 3'd0) ? 7'h30 : 7'h78;
            PFX_NIL: begin
                unique case (idx)
                    3'd0:    c = 7'h28;
                    3'd1:    c = 7'h6E;
                    3'd2:    c = 7'h69;
                    3'd3:    c = 7'h6C;
                    default: c = 7'h29;
                endcase
            end
            default:   c = 7'h30;
        endcase
        return c;
    endfunction

    // ASCII for one digit, letters in the selected case
    function automatic logic [CHAR_W-1:0] digit_char(logic upper, logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + {3'b000, d};
        end else if (upper) begin
            c = 7'h37 + {3'b000, d};
        end else begin
            c = 7'h57 + {3'b000, d};
        end
        return c;
    endfunction

endpackage

@@ hdl/i2a_digit_unit.sv @@
// Shared digit extraction unit: one division step by ten or sixteen.
// Depends on i2a_pkg.
module i2a_digit_unit (
    input  logic [i2a_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_decimal,
    output logic [i2a_pkg::VALUE_W-1:0] o_quot,
    output logic [3:0]                  o_digit
);

    logic [31:0] dec_x;
    logic [63:0] dec_prod;
    logic [28:0] dec_q;
    logic [31:0] dec_q10;

    // Divide the low word by ten through the reciprocal
    assign dec_x = i_value[31:0];
    assign dec_prod = {32'd0, dec_x} * {32'd0, i2a_pkg::RECIP_TEN};
    assign dec_q = dec_prod[63:35];
    assign dec_q10 = {dec_q[28:0], 3'b000} + {2'b00, dec_q[28:0], 1'b0};

    // Select decimal step or hex shift
    always_comb begin
        if (i_decimal) begin
            o_quot = {35'd0, dec_q};
            o_digit = dec_x[3:0] - dec_q10[3:0];
        end else begin
            o_quot = {4'd0, i_value[i2a_pkg::VALUE_W-1:4]};
            o_digit = i_value[3:0];
        end
    end

endmodule

@@ hdl/i2a_digit_stack.sv @@
// Digit stack: pushes extracted digits and pops them most significant first.
// Depends on i2a_pkg.
module i2a_digit_stack #(
    parameter int DEPTH = i2a_pkg::DIGIT_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  i2a_pkg::t_stack_ctl        i_ctl,
    input  logic [3:0]                 i_digit,
    output logic [3:0]                 o_top,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [3:0]    r_mem [DEPTH];
    logic [3:0]    r_top;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] below_idx;

    assign below_idx = r_count - CW'(2);
    assign o_top = r_top;
    assign o_count = r_count;

    // Track the fill level
    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Write the digit at the free slot; keep the top entry registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_count[AW-1:0]] <= i_digit;
            r_top <= i_digit;
        end else if (i_ctl.pop) begin
            r_top <= r_mem[below_idx[AW-1:0]];
        end
    end

endmodule

@@ hdl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter, top level: sequencer, output register, counter.
// An item is accepted while idle, then its prefix characters are loaded, its digits are
// extracted by the shared divide unit onto the stack and then emitted most significant
// first; prefix and emit wait on output stalls, and ready returns the cycle after the
// last beat is loaded, so the formatter handles one item at a time.
// Synchronous active-low reset clears the sequencer, the output valid and the total.
module integer_to_ascii_formatter #(
    parameter int DIGIT_DEPTH = i2a_pkg::DIGIT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [i2a_pkg::VALUE_W-1:0]    i_s_tdata,  // [63:0] value
    input  logic [i2a_pkg::OP_W-1:0]       i_s_tuser,  // [1:0] op
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [i2a_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [6:0] character, [37:7] char_total
    output logic                           o_m_tlast   // last
);

    localparam int CW = $clog2(DIGIT_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PREFIX = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [i2a_pkg::VALUE_W-1:0]     r_value, n_value;
    logic                            r_dec, n_dec;
    logic                            r_upper, n_upper;
    i2a_pkg::t_prefix                r_kind, n_kind;
    logic [2:0]                      r_idx, n_idx;
    logic [i2a_pkg::TOTAL_W-1:0]     r_total, n_total;
    logic                            r_out_valid;
    logic [i2a_pkg::CHAR_W-1:0]      r_out_char;
    logic                            r_out_last;
    logic [i2a_pkg::TOTAL_W-1:0]     r_out_total;

    logic                            out_free;
    logic                            load;
    logic [i2a_pkg::CHAR_W-1:0]      load_char;
    logic                            load_last;
    i2a_pkg::t_stack_ctl             stack_ctl;
    logic [i2a_pkg::VALUE_W-1:0]     unit_quot;
    logic [3:0]                      unit_digit;
    logic [3:0]                      stack_top;
    logic [CW-1:0]                   stack_count;
    logic [31:0]                     in_low;

    i2a_digit_unit u_unit (
        .i_value  (r_value),
        .i_decimal(r_dec),
        .o_quot   (unit_quot),
        .o_digit  (unit_digit)
    );

    i2a_digit_stack #(
        .DEPTH(DIGIT_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (stack_ctl),
        .i_digit(unit_digit),
        .o_top  (stack_top),
        .o_count(stack_count)
    );

    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_low = i_s_tdata[31:0];

    // Saturating character total
    assign n_total = (r_total == i2a_pkg::TOTAL_MAX) ? r_total
                                                     : r_total + i2a_pkg::TOTAL_W'(1);

    // Sequencer: capture, prefix, extract digits, emit digits
    always_comb begin
        n_state = r_state;
        n_value = r_value;
        n_dec = r_dec;
        n_upper = r_upper;
        n_kind = r_kind;
        n_idx = r_idx;
        load = 1'b0;
        load_char = '0;
        load_last = 1'b0;
        stack_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_idx = 3'd0;
                    n_dec = (i_s_tuser == i2a_pkg::OP_DEC);
                    n_upper = (i_s_tuser == i2a_pkg::OP_HEX_UP);
                    n_value = i_s_tdata;
                    n_kind = i2a_pkg::PFX_NONE;
                    if (i_s_tuser == i2a_pkg::OP_DEC) begin
                        n_value = {32'd0, in_low[31] ? (32'd0 - in_low) : in_low};
                        n_kind = in_low[31] ? i2a_pkg::PFX_MINUS : i2a_pkg::PFX_NONE;
                    end else if (i_s_tuser == i2a_pkg::OP_PTR) begin
                        n_kind = (i_s_tdata == '0) ? i2a_pkg::PFX_NIL : i2a_pkg::PFX_HEX;
                    end
                    n_state = (n_kind == i2a_pkg::PFX_NONE) ? S_DIVIDE : S_PREFIX;
                end
            end
            S_PREFIX: begin
                if (out_free) begin
                    load = 1'b1;
                    load_char = i2a_pkg::prefix_char(r_kind, r_idx);
                    if (r_idx == i2a_pkg::prefix_len(r_kind) - 3'd1) begin
                        if (r_kind == i2a_pkg::PFX_NIL) begin
                            load_last = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DIVIDE;
                        end
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            S_DIVIDE: begin
                stack_ctl.push = 1'b1;
                n_value = unit_quot;
                if (unit_quot == '0 || stack_count == CW'(DIGIT_DEPTH - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    stack_ctl.pop = 1'b1;
                    load = 1'b1;
                    load_char = i2a_pkg::digit_char(r_upper, stack_top);
                    if (stack_count == CW'(1)) begin
                        load_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_total <= n_total;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working value and output beat
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_dec <= n_dec;
        r_upper <= n_upper;
        r_kind <= n_kind;
        r_idx <= n_idx;
        if (load) begin
            r_out_char <= load_char;
            r_out_last <= load_last;
            r_out_total <= n_total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast = r_out_last;
    assign o_m_tdata = {2'b00, r_out_total, r_out_char};

endmodule
